// ===== rtl/agn_pkg.sv =====
// agn_pkg: shared types, constants and helper functions of the arc grid node generator
// holds the angle constants, the cordic arctangent table and the rounding helpers
// depends on nothing; every rtl file refers to it by scoped names
package agn_pkg;

    localparam int FIELD_W  = 10;
    localparam int EXT_W    = 16;
    localparam int NUM_W    = 31;
    localparam int COORD_W  = 32;
    localparam int MW       = 36;
    localparam int REM_W    = 35;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int INDEX_WIDTH_DEF   = 10;
    localparam int CORDIC_STAGES_DEF = 24;

    // pi in q60, angles in 2^-31 rad
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam longint PI_A      = longint'((PI_Q60 + (64'd1 << 28)) >> 29);
    localparam longint TWO_PI_A  = longint'((PI_Q60 + (64'd1 << 27)) >> 28);
    localparam longint HALF_PI_A = longint'((PI_Q60 + (64'd1 << 29)) >> 30);

    // 0.60725293500888 in q32
    localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

    // atan(2^-i) in 2^-31 rad
    localparam longint ATAN_TAB [32] = '{
        longint'(((PI_Q60 >> 2) + (64'd1 << 28)) >> 29),
        64'd995675659, 64'd526087673, 64'd267050317, 64'd134043374,
        64'd67087031,  64'd33551702,  64'd16776875,  64'd8388565,
        64'd4194299,   64'd2097151,   64'd1048576,   64'd524288,
        64'd262144,    64'd131072,    64'd65536,     64'd32768,
        64'd16384,     64'd8192,      64'd4096,      64'd2048,
        64'd1024,      64'd512,       64'd256,       64'd128,
        64'd64,        64'd32,        64'd16,        64'd8,
        64'd4,         64'd2,         64'd1
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INNER_RADIUS,
        CFG_RADIAL_STEP,
        CFG_ANGLE_STEP,
        CFG_AXIAL_START,
        CFG_AXIAL_STEP,
        CFG_COUNT_ANGULAR,
        CFG_COUNT_AXIAL,
        CFG_COUNT_RADIAL
    } t_cfg_reg;

    typedef struct packed {
        logic signed [MW-1:0] m;
        logic                 flip;
    } t_fold;

    typedef struct packed {
        logic [NUM_W-1:0]          num;
        logic signed [COORD_W-1:0] ny;
        logic signed [COORD_W-1:0] cy;
        logic                      valid;
    } t_side;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > 64'sh000000007FFFFFFF) begin
            r = 32'sh7FFFFFFF;
        end else if (v < 64'shFFFFFFFF80000000) begin
            r = 32'sh80000000;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    // 2^-21 units to q16.16, round half up
    function automatic logic signed [COORD_W-1:0] to_q16(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = (v + 64'sd16) >>> 5;
        return sat32(t);
    endfunction

    // remainder in [0, 2pi) to [-pi/2, pi/2] with half turn flag
    function automatic t_fold fold_angle(input logic [REM_W-1:0] u);
        logic signed [MW-1:0] m;
        t_fold r;
        m = $signed({1'b0, u});
        r.flip = 1'b0;
        if (m > MW'(PI_A)) begin
            m = m - MW'(TWO_PI_A);
        end
        if (m > MW'(HALF_PI_A)) begin
            m = m - MW'(PI_A);
            r.flip = 1'b1;
        end else if (m < -MW'(HALF_PI_A)) begin
            m = m + MW'(PI_A);
            r.flip = 1'b1;
        end
        r.m = m;
        return r;
    endfunction

endpackage

// ===== rtl/agn_reduce_cell.sv =====
// agn_reduce_cell: one restoring step of the angle reduction modulo two pi
// subtracts two pi shifted by K when it fits, registered
// depends on agn_pkg
module agn_reduce_cell #(
    parameter int AW = 45,
    parameter int K  = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [AW-1:0] i_u,
    output logic [AW-1:0] o_u
);

    localparam logic [AW-1:0] STEP = AW'(agn_pkg::TWO_PI_A << K);

    logic [AW-1:0] r_u;
    logic [AW-1:0] n_u;

    always_comb begin
        n_u = (i_u >= STEP) ? (i_u - STEP) : i_u;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u <= n_u;
        end
    end

    assign o_u = r_u;

endmodule

// ===== rtl/agn_cordic_cell.sv =====
// agn_cordic_cell: one rotation-mode cordic micro-rotation, registered
// shift and arctangent come from the stage number
// depends on agn_pkg
module agn_cordic_cell #(
    parameter int CW    = 42,
    parameter int MW    = agn_pkg::MW,
    parameter int SHIFT = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_c,
    input  logic signed [CW-1:0] i_s,
    input  logic signed [MW-1:0] i_m,
    output logic signed [CW-1:0] o_c,
    output logic signed [CW-1:0] o_s,
    output logic signed [MW-1:0] o_m
);

    localparam logic signed [MW-1:0] ATAN = MW'(agn_pkg::ATAN_TAB[SHIFT]);

    logic signed [CW-1:0] r_c, r_s, n_c, n_s;
    logic signed [MW-1:0] r_m, n_m;
    logic signed [CW-1:0] dc, ds;

    always_comb begin
        dc = i_s >>> SHIFT;
        ds = i_c >>> SHIFT;
        if (!i_m[MW-1]) begin
            n_c = i_c - dc;
            n_s = i_s + ds;
            n_m = i_m - ATAN;
        end else begin
            n_c = i_c + dc;
            n_s = i_s - ds;
            n_m = i_m + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c <= n_c;
            r_s <= n_s;
            r_m <= n_m;
        end
    end

    assign o_c = r_c;
    assign o_s = r_s;
    assign o_m = r_m;

endmodule

// ===== rtl/arc_grid_node_generator.sv =====
// arc_grid_node_generator: index triple to node and voxel centre position on an arc grid
// front products, two chains of angle reduction cells, a fold stage, then two chains of cordic cells
// depends on agn_pkg, agn_reduce_cell, agn_cordic_cell
//
//   channel  direction  handshake                  beat
//   in       to block   i_in_valid / o_in_stall    angular, axial, radial index
//   out      from block o_out_valid / i_out_stall  node number, node xyz, centre flag, centre xyz
//   cfg      to block   i_cfg_valid / o_cfg_ready  register index, write data
//
// one beat per cycle in and out, except while a waiting result is held under i_out_stall
// each reduction chain holds INDEX_WIDTH + 2 cells and each cordic chain CORDIC_STAGES cells
// the whole pipeline holds while a result waits under i_out_stall
// reset clears the stage valid bits and loads the register defaults; no clearing pass
module arc_grid_node_generator #(
    parameter int INDEX_WIDTH   = agn_pkg::INDEX_WIDTH_DEF,
    parameter int CORDIC_STAGES = agn_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [agn_pkg::FIELD_W-1:0]           i_angular_index,
    input  logic [agn_pkg::FIELD_W-1:0]           i_axial_index,
    input  logic [agn_pkg::FIELD_W-1:0]           i_radial_index,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [agn_pkg::NUM_W-1:0]             o_node_number,
    output logic signed [agn_pkg::COORD_W-1:0]    o_node_x,
    output logic signed [agn_pkg::COORD_W-1:0]    o_node_y,
    output logic signed [agn_pkg::COORD_W-1:0]    o_node_z,
    output logic                                  o_centre_valid,
    output logic signed [agn_pkg::COORD_W-1:0]    o_centre_x,
    output logic signed [agn_pkg::COORD_W-1:0]    o_centre_y,
    output logic signed [agn_pkg::COORD_W-1:0]    o_centre_z,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [agn_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [agn_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int IW  = INDEX_WIDTH;
    localparam int ST  = CORDIC_STAGES;
    localparam int NR  = IW + 2;
    localparam int AW  = IW + 35;
    localparam int AW1 = IW + 36;
    localparam int AGW = IW + 35;
    localparam int RW  = IW + 33;
    localparam int PW  = IW + 31;
    localparam int YW  = IW + 34;
    localparam int NPW = (3 * IW + 2 > agn_pkg::NUM_W) ? 3 * IW + 2 : agn_pkg::NUM_W;
    localparam int GHW = IW + 44;
    localparam int CW  = IW + 38;
    localparam int MW  = agn_pkg::MW;
    localparam int VD  = 3 + NR + ST;
    localparam int SD  = 2 + NR + ST;
    localparam logic [AW-1:0] ANG_OFFSET = AW'(agn_pkg::TWO_PI_A << IW);
    localparam logic signed [MW-1:0] HALF_A = MW'(agn_pkg::HALF_PI_A);

    // configuration registers
    logic [30:0]        r_inner_radius, r_radial_step, r_axial_step;
    logic [31:0]        r_angle_step;
    logic signed [31:0] r_axial_start;
    logic [9:0]         r_count_angular, r_count_axial, r_count_radial;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner_radius  <= '0;
            r_radial_step   <= '0;
            r_angle_step    <= '0;
            r_axial_start   <= '0;
            r_axial_step    <= '0;
            r_count_angular <= 10'd1;
            r_count_axial   <= 10'd1;
            r_count_radial  <= 10'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (agn_pkg::t_cfg_reg'(i_cfg_index))
                agn_pkg::CFG_INNER_RADIUS:  r_inner_radius  <= i_cfg_data[30:0];
                agn_pkg::CFG_RADIAL_STEP:   r_radial_step   <= i_cfg_data[30:0];
                agn_pkg::CFG_ANGLE_STEP:    r_angle_step    <= i_cfg_data;
                agn_pkg::CFG_AXIAL_START:   r_axial_start   <= $signed(i_cfg_data);
                agn_pkg::CFG_AXIAL_STEP:    r_axial_step    <= i_cfg_data[30:0];
                agn_pkg::CFG_COUNT_ANGULAR: r_count_angular <= i_cfg_data[9:0];
                agn_pkg::CFG_COUNT_AXIAL:   r_count_axial   <= i_cfg_data[9:0];
                agn_pkg::CFG_COUNT_RADIAL:  r_count_radial  <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic en;
    logic r_vld [VD];
    logic r_out_valid;

    assign en          = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < VD; j++) begin
                r_vld[j] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int j = 1; j < VD; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
            r_out_valid <= r_vld[VD-1];
        end
    end

    // front stage one: indices, products, angle
    logic [agn_pkg::EXT_W-1:0] a_ext, b_ext, c_ext, na_ext, nb_ext, nc_ext;
    logic [IW-1:0]             a, b, c, na, nb, nc;
    logic [IW:0]               na1, nb1;
    logic signed [IW+1:0]      diff;
    logic signed [AGW-1:0]     ang2;

    assign a_ext  = agn_pkg::EXT_W'(i_angular_index);
    assign b_ext  = agn_pkg::EXT_W'(i_axial_index);
    assign c_ext  = agn_pkg::EXT_W'(i_radial_index);
    assign na_ext = agn_pkg::EXT_W'(r_count_angular);
    assign nb_ext = agn_pkg::EXT_W'(r_count_axial);
    assign nc_ext = agn_pkg::EXT_W'(r_count_radial);
    assign a  = a_ext[IW-1:0];
    assign b  = b_ext[IW-1:0];
    assign c  = c_ext[IW-1:0];
    assign na = na_ext[IW-1:0];
    assign nb = nb_ext[IW-1:0];
    assign nc = nc_ext[IW-1:0];
    assign na1  = {1'b0, na} + (IW+1)'(1);
    assign nb1  = {1'b0, nb} + (IW+1)'(1);
    assign diff = $signed({1'b0, a, 1'b0}) - $signed({2'b00, na});
    assign ang2 = AGW'($signed({1'b0, r_angle_step})) * AGW'(diff);

    logic [IW-1:0]         r1_a, r1_c;
    logic                  r1_valid;
    logic signed [AGW-1:0] r1_ang2;
    logic [PW-1:0]         r1_crs, r1_by;
    logic [NPW-1:0]        r1_bna, r1_nab;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a     <= a;
            r1_c     <= c;
            r1_valid <= (a < na) && (b < nb) && (c < nc);
            r1_ang2  <= ang2;
            r1_crs   <= PW'(c) * PW'(r_radial_step);
            r1_by    <= PW'(b) * PW'(r_axial_step);
            r1_bna   <= NPW'(b) * NPW'(na1);
            r1_nab   <= NPW'(na1) * NPW'(nb1);
        end
    end

    // front stage two: radii, node number, axial, angle offset
    logic [RW-1:0]            rn, rc;
    logic [NPW-1:0]           numf;
    logic signed [YW-1:0]     ys, y2;
    logic signed [AW1-1:0]    ang_n, ang_c;
    agn_pkg::t_side           side_in;

    assign rn    = RW'({r_inner_radius, 1'b0}) + RW'({r1_crs, 1'b0});
    assign rc    = rn + RW'(r_radial_step);
    assign numf  = NPW'(1) + NPW'(r1_a) + r1_bna + NPW'(r1_c) * r1_nab;
    assign ys    = YW'(r_axial_start) + $signed(YW'(r1_by));
    assign y2    = (ys <<< 1) + $signed(YW'(r_axial_step)) + YW'(1);
    assign ang_n = AW1'(r1_ang2) + $signed({1'b0, ANG_OFFSET});
    assign ang_c = ang_n + $signed(AW1'({1'b0, r_angle_step}));

    always_comb begin
        side_in.num   = numf[agn_pkg::NUM_W-1:0];
        side_in.ny    = agn_pkg::sat32(64'(ys));
        side_in.cy    = agn_pkg::sat32(64'(y2 >>> 1));
        side_in.valid = r1_valid;
    end

    logic [RW-1:0]  r2_rn, r2_rc;
    logic [AW-1:0]  r2_u_n, r2_u_c;
    agn_pkg::t_side r_side [SD];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_rn     <= rn;
            r2_rc     <= rc;
            r2_u_n    <= ang_n[AW-1:0];
            r2_u_c    <= ang_c[AW-1:0];
            r_side[0] <= side_in;
            for (int j = 1; j < SD; j++) begin
                r_side[j] <= r_side[j-1];
            end
        end
    end

    // gain scaling of both radii
    logic [52:0]       plo_n, plo_c;
    logic [GHW-1:0]    r3_ph_n, r3_ph_c;
    logic [31:0]       r3_pl_n, r3_pl_c;
    logic [GHW-1:0]    gs_n, gs_c;
    logic signed [CW-1:0] r_c0_n [NR-1];
    logic signed [CW-1:0] r_c0_c [NR-1];

    assign plo_n = 53'(r2_rn[20:0]) * 53'(agn_pkg::GAIN_Q32);
    assign plo_c = 53'(r2_rc[20:0]) * 53'(agn_pkg::GAIN_Q32);
    assign gs_n  = r3_ph_n + GHW'(r3_pl_n);
    assign gs_c  = r3_ph_c + GHW'(r3_pl_c);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ph_n   <= GHW'(r2_rn[RW-1:21]) * GHW'(agn_pkg::GAIN_Q32);
            r3_ph_c   <= GHW'(r2_rc[RW-1:21]) * GHW'(agn_pkg::GAIN_Q32);
            r3_pl_n   <= plo_n[52:21];
            r3_pl_c   <= plo_c[52:21];
            r_c0_n[0] <= $signed(CW'(gs_n[GHW-1:7]));
            r_c0_c[0] <= $signed(CW'(gs_c[GHW-1:7]));
            for (int j = 1; j < NR - 1; j++) begin
                r_c0_n[j] <= r_c0_n[j-1];
                r_c0_c[j] <= r_c0_c[j-1];
            end
        end
    end

    // angle reduction chains
    logic [AW-1:0] u_n [NR+1];
    logic [AW-1:0] u_c [NR+1];

    assign u_n[0] = r2_u_n;
    assign u_c[0] = r2_u_c;

    for (genvar k = 0; k < NR; k++) begin : g_reduce
        agn_reduce_cell #(.AW(AW), .K(NR - 1 - k)) u_red_n (
            .i_clk (i_clk),
            .i_en  (en),
            .i_u   (u_n[k]),
            .o_u   (u_n[k+1])
        );
        agn_reduce_cell #(.AW(AW), .K(NR - 1 - k)) u_red_c (
            .i_clk (i_clk),
            .i_en  (en),
            .i_u   (u_c[k]),
            .o_u   (u_c[k+1])
        );
    end

    // fold stage
    agn_pkg::t_fold       fold_n, fold_c;
    logic signed [MW-1:0] r_f_m_n, r_f_m_c;
    logic                 r_f_flip_n, r_f_flip_c;
    logic signed [CW-1:0] r_f_c_n, r_f_c_c;

    assign fold_n = agn_pkg::fold_angle(u_n[NR][agn_pkg::REM_W-1:0]);
    assign fold_c = agn_pkg::fold_angle(u_c[NR][agn_pkg::REM_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_m_n    <= fold_n.m;
            r_f_m_c    <= fold_c.m;
            r_f_flip_n <= fold_n.flip;
            r_f_flip_c <= fold_c.flip;
            r_f_c_n    <= r_c0_n[NR-2];
            r_f_c_c    <= r_c0_c[NR-2];
        end
    end

    // cordic chains
    logic signed [CW-1:0] cn_c [ST+1];
    logic signed [CW-1:0] cn_s [ST+1];
    logic signed [MW-1:0] cn_m [ST+1];
    logic signed [CW-1:0] cc_c [ST+1];
    logic signed [CW-1:0] cc_s [ST+1];
    logic signed [MW-1:0] cc_m [ST+1];
    logic [1:0]           r_flip [ST];

    assign cn_c[0] = r_f_c_n;
    assign cn_s[0] = '0;
    assign cn_m[0] = r_f_m_n;
    assign cc_c[0] = r_f_c_c;
    assign cc_s[0] = '0;
    assign cc_m[0] = r_f_m_c;

    for (genvar i = 0; i < ST; i++) begin : g_cordic
        agn_cordic_cell #(.CW(CW), .MW(MW), .SHIFT(i)) u_cell_n (
            .i_clk (i_clk),
            .i_en  (en),
            .i_c   (cn_c[i]),
            .i_s   (cn_s[i]),
            .i_m   (cn_m[i]),
            .o_c   (cn_c[i+1]),
            .o_s   (cn_s[i+1]),
            .o_m   (cn_m[i+1])
        );
        agn_cordic_cell #(.CW(CW), .MW(MW), .SHIFT(i)) u_cell_c (
            .i_clk (i_clk),
            .i_en  (en),
            .i_c   (cc_c[i]),
            .i_s   (cc_s[i]),
            .i_m   (cc_m[i]),
            .o_c   (cc_c[i+1]),
            .o_s   (cc_s[i+1]),
            .o_m   (cc_m[i+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_flip[0] <= {r_f_flip_c, r_f_flip_n};
            for (int j = 1; j < ST; j++) begin
                r_flip[j] <= r_flip[j-1];
            end
        end
    end

    // output stage
    logic signed [CW-1:0]            vx_n, vz_n, vx_c, vz_c;
    agn_pkg::t_side                  side_out;
    logic [agn_pkg::NUM_W-1:0]       r_num;
    logic signed [agn_pkg::COORD_W-1:0] r_nx, r_ny, r_nz, r_cx, r_cy, r_cz;
    logic                            r_cv;

    assign side_out = r_side[SD-1];
    assign vx_n = r_flip[ST-1][0] ? -cn_s[ST] : cn_s[ST];
    assign vz_n = r_flip[ST-1][0] ? -cn_c[ST] : cn_c[ST];
    assign vx_c = r_flip[ST-1][1] ? -cc_s[ST] : cc_s[ST];
    assign vz_c = r_flip[ST-1][1] ? -cc_c[ST] : cc_c[ST];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num <= side_out.num;
            r_nx  <= agn_pkg::to_q16(64'(vx_n));
            r_ny  <= side_out.ny;
            r_nz  <= agn_pkg::to_q16(64'(vz_n));
            r_cv  <= side_out.valid;
            r_cx  <= side_out.valid ? agn_pkg::to_q16(64'(vx_c)) : '0;
            r_cy  <= side_out.valid ? side_out.cy : '0;
            r_cz  <= side_out.valid ? agn_pkg::to_q16(64'(vz_c)) : '0;
        end
    end

    assign o_node_number  = r_num;
    assign o_node_x       = r_nx;
    assign o_node_y       = r_ny;
    assign o_node_z       = r_nz;
    assign o_centre_valid = r_cv;
    assign o_centre_x     = r_cx;
    assign o_centre_y     = r_cy;
    assign o_centre_z     = r_cz;

    // checks
    a_centre_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_centre_valid) |->
            (o_centre_x == '0 && o_centre_y == '0 && o_centre_z == '0))
        else $error("centre not zero without a voxel");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input taken while result blocked");

    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2+NR] |-> (r_f_m_n <= HALF_A && r_f_m_n >= -HALF_A &&
                         r_f_m_c <= HALF_A && r_f_m_c >= -HALF_A))
        else $error("folded angle out of range");

    a_accept_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_vld[0])
        else $error("accepted beat lost at entry");

endmodule

// ===== tb/sv/tb_arc_grid_node_generator.sv =====
// tb_arc_grid_node_generator: self-checking bench for the arc grid node generator
// predicts node number, node and voxel centre positions per index triple, checks every output beat
// depends on agn_pkg and arc_grid_node_generator
`timescale 1ns / 100ps

class node_position_board;
    // register copy
    longint unsigned inner_radius;
    longint unsigned radial_step;
    longint unsigned angle_step;
    longint          axial_start;
    longint unsigned axial_step;
    longint unsigned count_angular;
    longint unsigned count_axial;
    longint unsigned count_radial;

    logic [30:0] exp_num[$];
    logic [31:0] exp_nx[$], exp_ny[$], exp_nz[$];
    logic        exp_cv[$];
    logic [31:0] exp_cx[$], exp_cy[$], exp_cz[$];
    int          mismatches;
    int          checked;
    longint      atan_q31[32];

    function new();
        longint s, t;
        int k;
        set_defaults();
        mismatches = 0;
        checked = 0;
        for (int i = 0; i < 32; i++) begin
            s = 0;
            if (i == 0) begin
                s = longint'(agn_pkg::PI_Q60) >>> 2;
            end else begin
                for (k = 0; 60 - i * (2 * k + 1) >= 0; k++) begin
                    t = (64'sd1 <<< (60 - i * (2 * k + 1))) / longint'(2 * k + 1);
                    s = (k & 1) ? s - t : s + t;
                end
            end
            atan_q31[i] = (s + (64'sd1 <<< 28)) >>> 29;
        end
    endfunction

    function void set_defaults();
        inner_radius = 0;
        radial_step = 0;
        angle_step = 0;
        axial_start = 0;
        axial_step = 0;
        count_angular = 1;
        count_axial = 1;
        count_radial = 1;
    endfunction

    function void write_reg(agn_pkg::t_cfg_reg idx, logic [31:0] v);
        case (idx)
            agn_pkg::CFG_INNER_RADIUS:  inner_radius = 64'(v[30:0]);
            agn_pkg::CFG_RADIAL_STEP:   radial_step = 64'(v[30:0]);
            agn_pkg::CFG_ANGLE_STEP:    angle_step = 64'(v);
            agn_pkg::CFG_AXIAL_START:   axial_start = longint'(signed'(v));
            agn_pkg::CFG_AXIAL_STEP:    axial_step = 64'(v[30:0]);
            agn_pkg::CFG_COUNT_ANGULAR: count_angular = 64'(v[9:0]);
            agn_pkg::CFG_COUNT_AXIAL:   count_axial = 64'(v[9:0]);
            agn_pkg::CFG_COUNT_RADIAL:  count_radial = 64'(v[9:0]);
            default: ;
        endcase
    endfunction

    static function longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    static function longint round_q16(longint v);
        return clamp32((v + 16) >>> 5);
    endfunction

    // radius in 2^-17, angle in 2^-31 rad
    function void rotate(longint unsigned r2, longint ang, output longint px, output longint pz);
        longint unsigned hi, lo;
        longint c, s, m, dc, ds;
        bit flip;
        hi = r2 >> 21;
        lo = r2 & 64'h1FFFFF;
        c = longint'((hi * 64'd2608131496 + ((lo * 64'd2608131496) >> 21)) >> 7);
        s = 0;
        flip = 0;
        m = ang % agn_pkg::TWO_PI_A;
        if (m < 0) m += agn_pkg::TWO_PI_A;
        if (m > agn_pkg::PI_A) m -= agn_pkg::TWO_PI_A;
        if (m > agn_pkg::HALF_PI_A) begin
            m -= agn_pkg::PI_A;
            flip = 1;
        end else if (m < -agn_pkg::HALF_PI_A) begin
            m += agn_pkg::PI_A;
            flip = 1;
        end
        for (int i = 0; i < 24; i++) begin
            dc = s >>> i;
            ds = c >>> i;
            if (m >= 0) begin
                c -= dc;
                s += ds;
                m -= atan_q31[i];
            end else begin
                c += dc;
                s -= ds;
                m += atan_q31[i];
            end
        end
        if (flip) begin
            c = -c;
            s = -s;
        end
        px = round_q16(s);
        pz = round_q16(c);
    endfunction

    function void note_triple(logic [9:0] a, logic [9:0] b, logic [9:0] c);
        longint unsigned ua, ub, uc, num;
        longint sa, ang2, nx, nz, ny, cx, cy, cz, y2;
        bit v;
        ua = 64'(a);
        ub = 64'(b);
        uc = 64'(c);
        sa = longint'(angle_step);
        ang2 = sa * (longint'(2 * ua) - longint'(count_angular));
        v = (ua < count_angular) && (ub < count_axial) && (uc < count_radial);
        num = 1 + ua + ub * (count_angular + 1)
            + uc * (count_angular + 1) * (count_axial + 1);
        rotate(2 * inner_radius + 2 * uc * radial_step, ang2, nx, nz);
        ny = clamp32(axial_start + longint'(ub * axial_step));
        cx = 0;
        cy = 0;
        cz = 0;
        if (v) begin
            rotate(2 * inner_radius + (2 * uc + 1) * radial_step, ang2 + sa, cx, cz);
            y2 = 2 * axial_start + longint'((2 * ub + 1) * axial_step);
            cy = clamp32((y2 + 1) >>> 1);
        end
        exp_num = {exp_num, num[30:0]};
        exp_nx = {exp_nx, nx[31:0]};
        exp_ny = {exp_ny, ny[31:0]};
        exp_nz = {exp_nz, nz[31:0]};
        exp_cv = {exp_cv, v};
        exp_cx = {exp_cx, cx[31:0]};
        exp_cy = {exp_cy, cy[31:0]};
        exp_cz = {exp_cz, cz[31:0]};
    endfunction

    function void check_beat(logic [30:0] num, logic [31:0] nx, logic [31:0] ny,
                             logic [31:0] nz, logic cv, logic [31:0] cx,
                             logic [31:0] cy, logic [31:0] cz);
        logic [30:0] enum_v;
        logic [31:0] ex, ey, ez, ecx, ecy, ecz;
        logic ecv;
        if (exp_num.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected output beat num=%0d", num);
            return;
        end
        enum_v = exp_num.pop_front();
        ex = exp_nx.pop_front();
        ey = exp_ny.pop_front();
        ez = exp_nz.pop_front();
        ecv = exp_cv.pop_front();
        ecx = exp_cx.pop_front();
        ecy = exp_cy.pop_front();
        ecz = exp_cz.pop_front();
        checked++;
        if ({num, nx, ny, nz, cv, cx, cy, cz} !== {enum_v, ex, ey, ez, ecv, ecx, ecy, ecz}) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch beat %0d exp num=%0d n=(%h %h %h) cv=%b c=(%h %h %h)",
                         checked, enum_v, ex, ey, ez, ecv, ecx, ecy, ecz);
                $display("                 got num=%0d n=(%h %h %h) cv=%b c=(%h %h %h)",
                         num, nx, ny, nz, cv, cx, cy, cz);
            end
        end
    endfunction

    function int pending();
        return exp_num.size();
    endfunction
endclass

module tb_arc_grid_node_generator;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [9:0]  i_angular_index;
    logic [9:0]  i_axial_index;
    logic [9:0]  i_radial_index;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [30:0] o_node_number;
    logic signed [31:0] o_node_x, o_node_y, o_node_z;
    logic        o_centre_valid;
    logic signed [31:0] o_centre_x, o_centre_y, o_centre_z;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    node_position_board board;
    int sent;
    int centres_seen;
    bit stall_enable;

    arc_grid_node_generator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_angular_index (i_angular_index),
        .i_axial_index   (i_axial_index),
        .i_radial_index  (i_radial_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_node_number   (o_node_number),
        .o_node_x        (o_node_x),
        .o_node_y        (o_node_y),
        .o_node_z        (o_node_z),
        .o_centre_valid  (o_centre_valid),
        .o_centre_x      (o_centre_x),
        .o_centre_y      (o_centre_y),
        .o_centre_z      (o_centre_z),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // waits until nothing is in flight, then writes one register
    task automatic write_reg(agn_pkg::t_cfg_reg idx, logic [31:0] v);
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, v);
    endtask

    task automatic send_triple(logic [9:0] a, logic [9:0] b, logic [9:0] c, bit gaps);
        int g;
        g = gaps ? int'($urandom_range(0, 10)) : 0;
        i_cfg_valid <= 1'b0;
        if (g != 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_angular_index <= a;
        i_axial_index <= b;
        i_radial_index <= c;
        do @(posedge i_clk); while (o_in_stall);
        board.note_triple(a, b, c);
        sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // receiver: stall drawn per beat
    initial begin
        int w;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall && i_rst_n) begin
                board.check_beat(o_node_number, o_node_x, o_node_y, o_node_z, o_centre_valid,
                                 o_centre_x, o_centre_y, o_centre_z);
                if (o_centre_valid) centres_seen++;
                w = stall_enable ? int'($urandom_range(0, 10)) : 0;
                if (w != 0) begin
                    i_out_stall <= 1'b1;
                    repeat (w) begin
                        @(posedge i_clk);
                        if (o_out_valid && !i_out_stall && i_rst_n) board.check_beat(
                            o_node_number, o_node_x, o_node_y, o_node_z, o_centre_valid,
                            o_centre_x, o_centre_y, o_centre_z);
                    end
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("tb_arc_grid_node_generator NOT OK");
        $finish;
    end

    task automatic random_config(int mode);
        write_reg(agn_pkg::CFG_INNER_RADIUS,
                  mode == 0 ? 32'h7FFFFFFF : {1'b0, 15'($urandom), 16'($urandom)});
        write_reg(agn_pkg::CFG_RADIAL_STEP,
                  mode == 0 ? 32'h7FFFFFFF : 32'($urandom_range(0, 32'h0010_0000)));
        write_reg(agn_pkg::CFG_ANGLE_STEP,
                  mode == 0 ? 32'd3373259426 : 32'($urandom_range(0, 32'h0800_0000)));
        write_reg(agn_pkg::CFG_AXIAL_START, $urandom);
        write_reg(agn_pkg::CFG_AXIAL_STEP,
                  mode == 0 ? 32'h7FFFFFFF : {1'b0, 31'($urandom)} >> $urandom_range(0, 20));
        write_reg(agn_pkg::CFG_COUNT_ANGULAR,
                  mode == 0 ? 32'd1023 : 32'($urandom_range(0, 40)));
        write_reg(agn_pkg::CFG_COUNT_AXIAL,
                  mode == 0 ? 32'd1023 : 32'($urandom_range(0, 40)));
        write_reg(agn_pkg::CFG_COUNT_RADIAL,
                  mode == 0 ? 32'd1023 : 32'($urandom_range(0, 40)));
    endtask

    initial begin
        logic [9:0] a, b, c;
        board = new();
        sent = 0;
        centres_seen = 0;
        stall_enable = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_angular_index = '0;
        i_axial_index = '0;
        i_radial_index = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults, then extremes
        send_triple(10'd0, 10'd0, 10'd0, 0);
        send_triple(10'd1023, 10'd1023, 10'd1023, 0);
        drain();
        random_config(0);
        send_triple(10'd0, 10'd0, 10'd0, 0);
        send_triple(10'd1022, 10'd1022, 10'd1022, 0);
        send_triple(10'd1023, 10'd0, 10'd0, 0);
        send_triple(10'd0, 10'd1023, 10'd0, 0);
        send_triple(10'd0, 10'd0, 10'd1023, 0);
        send_triple(10'd511, 10'd511, 10'd0, 0);
        drain();
        // small arc, zero counts, half axial step
        write_reg(agn_pkg::CFG_INNER_RADIUS, 32'h0010_0000);
        write_reg(agn_pkg::CFG_RADIAL_STEP, 32'h0000_8000);
        write_reg(agn_pkg::CFG_ANGLE_STEP, 32'h0100_0000);
        write_reg(agn_pkg::CFG_AXIAL_START, 32'hFFFF_0000);
        write_reg(agn_pkg::CFG_AXIAL_STEP, 32'h0000_0001);
        write_reg(agn_pkg::CFG_COUNT_ANGULAR, 32'd0);
        write_reg(agn_pkg::CFG_COUNT_AXIAL, 32'd4);
        write_reg(agn_pkg::CFG_COUNT_RADIAL, 32'd4);
        send_triple(10'd0, 10'd1, 10'd1, 0);
        write_reg(agn_pkg::CFG_COUNT_ANGULAR, 32'd8);
        send_triple(10'd3, 10'd2, 10'd1, 0);
        send_triple(10'd8, 10'd2, 10'd1, 0);
        send_triple(10'd7, 10'd3, 10'd3, 0);
        drain();
        write_reg(agn_pkg::CFG_AXIAL_START, 32'h8000_0000);
        write_reg(agn_pkg::CFG_AXIAL_STEP, 32'h0000_0003);
        send_triple(10'd2, 10'd0, 10'd0, 0);
        send_triple(10'd2, 10'd3, 10'd0, 0);
        drain();

        stall_enable = 1'b1;
        for (int phase = 0; phase < 8; phase++) begin
            random_config(phase == 7 ? 0 : 1);
            for (int k = 0; k < 140; k++) begin
                if ($urandom_range(0, 9) < 7) begin
                    a = 10'($urandom_range(0, board.count_angular + 1));
                    b = 10'($urandom_range(0, board.count_axial + 1));
                    c = 10'($urandom_range(0, board.count_radial + 1));
                end else begin
                    a = 10'($urandom);
                    b = 10'($urandom);
                    c = 10'($urandom);
                end
                send_triple(a, b, c, phase % 3 != 2);
                if (k == 70 && phase == 3) begin
                    i_in_valid <= 1'b0;
                    while (board.pending() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        $display("covered %0d index triples over ten register settings, %0d checked beats",
                 sent, board.checked);
        $display("mismatches: %0d, voxel centres seen: %0d", board.mismatches, centres_seen);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("tb_arc_grid_node_generator OK");
        end else begin
            $display("tb_arc_grid_node_generator NOT OK");
        end
        $finish;
    end
endmodule
